// ===== design/ppm_pkg.sv =====
`timescale 1ns / 1ps

package ppm_pkg;

	localparam int CHANNEL_COUNT = 6;
	localparam int OUT_SLOTS = 6;
	localparam int STORE_DEPTH = 8;
	localparam int SLOT_W = $clog2(STORE_DEPTH);
	localparam int PW_W = 16;
	localparam int CH_W = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CH_W-1:0] NEUTRAL_WIDTH = CH_W'(1500);
	localparam logic [PW_W-1:0] SILENCE_MAX = {PW_W{1'b1}};

	localparam logic OP_PULSE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_THRESHOLD = 3'd0,
		REG_PULSE_MINIMUM = 3'd1,
		REG_PULSE_MAXIMUM = 3'd2,
		REG_ARM_THROTTLE_LIMIT = 3'd3,
		REG_YAW_ARM_LEVEL = 3'd4,
		REG_YAW_DISARM_LEVEL = 3'd5,
		REG_FAILSAFE_TIMEOUT_MS = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [PW_W-1:0] sync_threshold;
		logic [CH_W-1:0] pulse_minimum;
		logic [CH_W-1:0] pulse_maximum;
		logic [CH_W-1:0] arm_throttle_limit;
		logic [CH_W-1:0] yaw_arm_level;
		logic [CH_W-1:0] yaw_disarm_level;
		logic [PW_W-1:0] failsafe_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [OUT_SLOTS-1:0][CH_W-1:0] channel;
		logic frame_done;
		logic armed_flag;
		logic failsafe_active;
	} res_t;

	function automatic logic [CH_W-1:0] chan_read(input logic [CH_W-1:0] w, input cfg_t cfg);
		chan_read = (w >= cfg.pulse_minimum && w <= cfg.pulse_maximum) ? w : NEUTRAL_WIDTH;
	endfunction

endpackage

// ===== design/ppm_ifs.sv =====
`timescale 1ns / 1ps

interface ppm_in_if import ppm_pkg::*; ();
	logic valid;
	logic ready;
	logic op;
	logic [PW_W-1:0] pulse_us;

	modport source (output valid, output op, output pulse_us, input ready);
	modport sink (input valid, input op, input pulse_us, output ready);
endinterface

interface ppm_out_if import ppm_pkg::*; ();
	logic valid;
	logic ready;
	logic [CH_W-1:0] roll_channel;
	logic [CH_W-1:0] pitch_channel;
	logic [CH_W-1:0] throttle_channel;
	logic [CH_W-1:0] yaw_channel;
	logic [CH_W-1:0] aux_one_channel;
	logic [CH_W-1:0] aux_two_channel;
	logic frame_done;
	logic armed_flag;
	logic failsafe_active;

	modport source (output valid, output roll_channel, output pitch_channel,
		output throttle_channel, output yaw_channel, output aux_one_channel,
		output aux_two_channel, output frame_done, output armed_flag,
		output failsafe_active, input ready);
	modport sink (input valid, input roll_channel, input pitch_channel,
		input throttle_channel, input yaw_channel, input aux_one_channel,
		input aux_two_channel, input frame_done, input armed_flag,
		input failsafe_active, output ready);
endinterface

// ===== design/ppm_cfg_regs.sv =====
`timescale 1ns / 1ps

module ppm_cfg_regs import ppm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic we,
	input logic [CFG_IDX_W-1:0] index,
	input logic [CFG_DATA_W-1:0] data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_threshold <= PW_W'(3000);
			cfg_q.pulse_minimum <= CH_W'(900);
			cfg_q.pulse_maximum <= CH_W'(2100);
			cfg_q.arm_throttle_limit <= CH_W'(1300);
			cfg_q.yaw_arm_level <= CH_W'(1800);
			cfg_q.yaw_disarm_level <= CH_W'(1200);
			cfg_q.failsafe_timeout_ms <= PW_W'(1000);
		end else if (we) begin
			unique case (cfg_reg_t'(index))
				REG_SYNC_THRESHOLD: cfg_q.sync_threshold <= data[PW_W-1:0];
				REG_PULSE_MINIMUM: cfg_q.pulse_minimum <= data[CH_W-1:0];
				REG_PULSE_MAXIMUM: cfg_q.pulse_maximum <= data[CH_W-1:0];
				REG_ARM_THROTTLE_LIMIT: cfg_q.arm_throttle_limit <= data[CH_W-1:0];
				REG_YAW_ARM_LEVEL: cfg_q.yaw_arm_level <= data[CH_W-1:0];
				REG_YAW_DISARM_LEVEL: cfg_q.yaw_disarm_level <= data[CH_W-1:0];
				REG_FAILSAFE_TIMEOUT_MS: cfg_q.failsafe_timeout_ms <= data[PW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/ppm_frame_core.sv =====
`timescale 1ns / 1ps

module ppm_frame_core import ppm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic go,
	input logic op,
	input logic [PW_W-1:0] pulse_us,
	output res_t res
);

	logic [STORE_DEPTH-1:0][CH_W-1:0] store_q;
	logic [STORE_DEPTH-1:0][CH_W-1:0] store_d;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_d;
	logic [PW_W-1:0] prev_q;
	logic [PW_W-1:0] prev_d;
	logic armed_q;
	logic armed_d;
	logic [PW_W-1:0] silence_q;
	logic [PW_W-1:0] silence_d;
	logic [SLOT_W-1:0] idx;
	logic [SLOT_W:0] idx_next;
	logic in_window;
	logic done;
	logic fail;
	logic [CH_W-1:0] thr;
	logic [CH_W-1:0] yaw;

	always_comb begin
		store_d = store_q;
		slot_d = slot_q;
		prev_d = prev_q;
		silence_d = silence_q;
		armed_d = armed_q;
		done = 1'b0;
		idx = (prev_q > cfg.sync_threshold) ? '0 : slot_q;
		idx_next = {1'b0, idx} + 1'b1;
		in_window = pulse_us >= {{(PW_W-CH_W){1'b0}}, cfg.pulse_minimum} &&
			pulse_us <= {{(PW_W-CH_W){1'b0}}, cfg.pulse_maximum};
		if (op == OP_PULSE) begin
			prev_d = pulse_us;
			if (in_window) begin
				store_d[idx] = pulse_us[CH_W-1:0];
				if (idx_next >= (SLOT_W+1)'(CHANNEL_COUNT)) begin
					done = 1'b1;
					slot_d = '0;
					silence_d = '0;
				end else begin
					slot_d = idx_next[SLOT_W-1:0];
				end
			end
		end else if (silence_q != SILENCE_MAX) begin
			silence_d = silence_q + 1'b1;
		end
		thr = chan_read(store_d[2], cfg);
		yaw = chan_read(store_d[3], cfg);
		if (done && thr < cfg.arm_throttle_limit) begin
			if (yaw > cfg.yaw_arm_level) begin
				armed_d = 1'b1;
			end
			if (yaw < cfg.yaw_disarm_level) begin
				armed_d = 1'b0;
			end
		end
		fail = silence_d > cfg.failsafe_timeout_ms;
		if (fail) begin
			armed_d = 1'b0;
		end
		for (int k = 0; k < OUT_SLOTS; k++) begin
			res.channel[k] = chan_read(store_d[k], cfg);
		end
		res.frame_done = done;
		res.armed_flag = armed_d;
		res.failsafe_active = fail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STORE_DEPTH; k++) begin
				store_q[k] <= NEUTRAL_WIDTH;
			end
			slot_q <= '0;
			prev_q <= '0;
			armed_q <= 1'b0;
			silence_q <= '0;
		end else if (go) begin
			store_q <= store_d;
			slot_q <= slot_d;
			prev_q <= prev_d;
			armed_q <= armed_d;
			silence_q <= silence_d;
		end
	end

endmodule

// ===== design/ppm_decoder_with_arming_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Contents
// request   in         op, pulse_us
// result    out        six channels, frame_done, armed_flag, failsafe_active
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// Each request goes into an input register, is decoded there against the frame
// state and lands in the result register, so one request per cycle is sustained
// while the result is not stalled. Reset clears all control state and loads the
// register defaults and the neutral channel values. A stalled result holds the
// result register and the input register; a new request is taken as soon as the
// input register moves.

module ppm_decoder_with_arming_top import ppm_pkg::*; (
	input logic clk,
	input logic arst_n,
	ppm_in_if.sink request,
	ppm_out_if.source result,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	res_t res;
	res_t res_s2;
	logic valid_s1;
	logic op_s1;
	logic [PW_W-1:0] pw_s1;
	logic valid_s2;
	logic advance;

	ppm_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.we(cfg_we),
		.index(cfg_index),
		.data(cfg_data),
		.cfg(cfg)
	);

	ppm_frame_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.go(advance),
		.op(op_s1),
		.pulse_us(pw_s1),
		.res(res)
	);

	assign advance = valid_s1 && (!valid_s2 || result.ready);
	assign request.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (request.ready) begin
				valid_s1 <= request.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			op_s1 <= request.op;
			pw_s1 <= request.pulse_us;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result.valid = valid_s2;
	assign result.roll_channel = res_s2.channel[0];
	assign result.pitch_channel = res_s2.channel[1];
	assign result.throttle_channel = res_s2.channel[2];
	assign result.yaw_channel = res_s2.channel[3];
	assign result.aux_one_channel = res_s2.channel[4];
	assign result.aux_two_channel = res_s2.channel[5];
	assign result.frame_done = res_s2.frame_done;
	assign result.armed_flag = res_s2.armed_flag;
	assign result.failsafe_active = res_s2.failsafe_active;

endmodule
